@@ rtl/mfh_pkg.sv @@
// shared types and constants of the mqtt fixed header framer
package mfh_pkg;

   localparam int DATA_W = 8;
   localparam int LEN_W  = 28;
   localparam int NIB_W  = 4;
   localparam int IDX_W  = 2;

   localparam logic [LEN_W-1:0] MAX_SIZE_RESET = LEN_W'(4096);
   localparam logic [IDX_W-1:0] LAST_LEN_IDX   = IDX_W'(3);
   localparam int               GROUP_W        = 7;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_LENGTH = 2'd1,
      PH_BODY   = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      ROLE_HEADER = 2'd0,
      ROLE_LENGTH = 2'd1,
      ROLE_BODY   = 2'd2
   } byte_role_type;

   typedef struct packed {
      byte_role_type    byte_role;
      logic [NIB_W-1:0] packet_type;
      logic [NIB_W-1:0] header_flags;
      logic [LEN_W-1:0] packet_length;
      logic [LEN_W-1:0] bytes_left;
      logic             too_big;
      logic             length_error;
      logic             packet_done;
   } result_type;

   typedef struct packed {
      logic              valid;
      logic [DATA_W-1:0] data_byte;
   } staged_type;

endpackage

@@ rtl/mfh_if.sv @@
// request and response channel interfaces

interface mfh_req_if;
   import mfh_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface mfh_rsp_if;
   import mfh_pkg::*;

   logic             valid;
   logic             ready;
   logic [1:0]       byte_role;
   logic [NIB_W-1:0] packet_type;
   logic [NIB_W-1:0] header_flags;
   logic [LEN_W-1:0] packet_length;
   logic [LEN_W-1:0] bytes_left;
   logic             too_big;
   logic             length_error;
   logic             packet_done;

   modport source (
      output valid, output byte_role, output packet_type, output header_flags,
      output packet_length, output bytes_left, output too_big,
      output length_error, output packet_done, input ready
   );
   modport sink (
      input valid, input byte_role, input packet_type, input header_flags,
      input packet_length, input bytes_left, input too_big,
      input length_error, input packet_done, output ready
   );
endinterface

@@ rtl/mfh_in_reg.sv @@
// input register stage holding one request byte
module mfh_in_reg (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic [mfh_pkg::DATA_W-1:0] req_data_byte,
   output logic                      req_ready,
   input  logic                      advance,
   output mfh_pkg::staged_type       staged
);
   import mfh_pkg::*;

   logic              valid_ff, valid_in;
   logic [DATA_W-1:0] byte_ff, byte_in;
   logic              take;

   assign req_ready = !valid_ff || advance;
   assign take      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (take) begin
         valid_in = 1'b1;
         byte_in  = req_data_byte;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign staged.valid     = valid_ff;
   assign staged.data_byte = byte_ff;
endmodule

@@ rtl/mfh_decoder.sv @@
// framing state machine and per-byte result logic
module mfh_decoder (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [mfh_pkg::LEN_W-1:0] csr_wr_data,
   input  logic                      advance,
   input  logic [mfh_pkg::DATA_W-1:0] data_byte,
   output mfh_pkg::result_type       result
);
   import mfh_pkg::*;

   phase_type         phase_ff, phase_in;
   logic [LEN_W-1:0]  max_size_ff;
   logic [LEN_W-1:0]  accum_ff, accum_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [LEN_W-1:0]  body_ff, body_in;
   logic              big_ff, big_in;
   logic [DATA_W-1:0] header_ff, header_in;

   logic [LEN_W-1:0]  group_ext;
   logic [LEN_W-1:0]  accum_merged;
   logic [LEN_W-1:0]  body_dec;
   logic              more;
   logic              last_idx;

   assign group_ext = LEN_W'(data_byte[GROUP_W-1:0]);
   assign more      = data_byte[DATA_W-1];
   assign last_idx  = (idx_ff == LAST_LEN_IDX);
   assign body_dec  = body_ff - LEN_W'(1);

   // place the 7-bit group at the current length byte position
   always_comb begin
      case (idx_ff)
         2'd0:    accum_merged = accum_ff | group_ext;
         2'd1:    accum_merged = accum_ff | (group_ext << GROUP_W);
         2'd2:    accum_merged = accum_ff | (group_ext << (2 * GROUP_W));
         default: accum_merged = accum_ff | (group_ext << (3 * GROUP_W));
      endcase
   end

   // next phase
   always_comb begin
      unique case (phase_ff)
         PH_LENGTH: begin
            if (more) begin
               phase_in = last_idx ? PH_HEADER : PH_LENGTH;
            end else begin
               phase_in = (accum_merged == '0) ? PH_HEADER : PH_BODY;
            end
         end
         PH_BODY: begin
            phase_in = (body_dec == '0) ? PH_HEADER : PH_BODY;
         end
         default: begin
            phase_in = PH_LENGTH;
         end
      endcase
   end

   // result fields and data state
   always_comb begin
      accum_in  = accum_ff;
      idx_in    = idx_ff;
      body_in   = body_ff;
      big_in    = big_ff;
      header_in = header_ff;

      result.byte_role     = ROLE_HEADER;
      result.packet_length = '0;
      result.bytes_left    = '0;
      result.too_big       = 1'b0;
      result.length_error  = 1'b0;
      result.packet_done   = 1'b0;

      unique case (phase_ff)
         PH_LENGTH: begin
            result.byte_role = ROLE_LENGTH;
            accum_in         = accum_merged;
            if (more) begin
               if (last_idx) begin
                  result.length_error = 1'b1;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end else begin
               big_in               = (accum_merged > max_size_ff);
               body_in              = accum_merged;
               result.packet_length = accum_merged;
               result.bytes_left    = accum_merged;
               result.too_big       = big_in;
               result.packet_done   = (accum_merged == '0);
            end
         end
         PH_BODY: begin
            result.byte_role     = ROLE_BODY;
            body_in              = body_dec;
            result.packet_length = accum_ff;
            result.bytes_left    = body_dec;
            result.too_big       = big_ff;
            result.packet_done   = (body_dec == '0);
         end
         default: begin
            header_in = data_byte;
            accum_in  = '0;
            idx_in    = '0;
            body_in   = '0;
            big_in    = 1'b0;
         end
      endcase

      result.packet_type  = header_in[DATA_W-1:NIB_W];
      result.header_flags = header_in[NIB_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         max_size_ff <= MAX_SIZE_RESET;
         accum_ff    <= '0;
         idx_ff      <= '0;
         body_ff     <= '0;
         big_ff      <= 1'b0;
         header_ff   <= '0;
      end else begin
         if (csr_wr_en) begin
            max_size_ff <= csr_wr_data;
         end
         if (advance) begin
            phase_ff  <= phase_in;
            accum_ff  <= accum_in;
            idx_ff    <= idx_in;
            body_ff   <= body_in;
            big_ff    <= big_in;
            header_ff <= header_in;
         end
      end
   end
endmodule

@@ rtl/mfh_out_reg.sv @@
// response register holding one finished result
module mfh_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                staged_valid,
   input  mfh_pkg::result_type result,
   input  logic                rsp_ready,
   output logic                advance,
   output logic                rsp_valid,
   output mfh_pkg::result_type rsp_result
);
   import mfh_pkg::*;

   logic       valid_ff, valid_in;
   result_type result_ff, result_in;

   // move on when the slot is empty or being emptied this cycle
   assign advance = staged_valid && (!valid_ff || rsp_ready);

   always_comb begin
      valid_in  = valid_ff;
      result_in = result_ff;
      if (advance) begin
         valid_in  = 1'b1;
         result_in = result;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      result_ff <= result_in;
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;
endmodule

@@ rtl/mqtt_fixed_header_framer.sv @@
// top level of the mqtt fixed header framer
//
//   channel   dir  handshake       contents
//   req_chan  in   valid / ready   data_byte, one stream byte per request
//   rsp_chan  out  valid / ready   role, header nibbles, lengths, flags per byte
//   csr_*     in   write enable    max_message_size, 28 bits
//
// one request a cycle sustained while responses are taken; a byte taken from the
// request port passes the input register, then decode into the response register
// reset is synchronous: framer waits for a header, size limit returns to 4096
// a stalled response holds its register; the input register still takes a byte
// when the response is being taken in the same cycle, so no bubble on release
module mqtt_fixed_header_framer (
   input  logic                      clock,
   input  logic                      reset,
   mfh_req_if.sink                   req_chan,
   mfh_rsp_if.source                 rsp_chan,
   input  logic                      csr_wr_en,
   input  logic [mfh_pkg::LEN_W-1:0] csr_wr_data
);
   import mfh_pkg::*;

   staged_type staged;
   result_type result;
   result_type rsp_result;
   logic       advance;

   // input register: holds one request byte; when full, request ready follows the response side
   mfh_in_reg u_in_reg (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_data_byte (req_chan.data_byte),
      .req_ready     (req_chan.ready),
      .advance       (advance),
      .staged        (staged)
   );

   // framing state, length accumulation, size compare and body countdown
   mfh_decoder u_decoder (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .advance     (advance),
      .data_byte   (staged.data_byte),
      .result      (result)
   );

   // response register: state commits only when a result moves in here
   mfh_out_reg u_out_reg (
      .clock        (clock),
      .reset        (reset),
      .staged_valid (staged.valid),
      .result       (result),
      .rsp_ready    (rsp_chan.ready),
      .advance      (advance),
      .rsp_valid    (rsp_chan.valid),
      .rsp_result   (rsp_result)
   );

   assign rsp_chan.byte_role     = rsp_result.byte_role;
   assign rsp_chan.packet_type   = rsp_result.packet_type;
   assign rsp_chan.header_flags  = rsp_result.header_flags;
   assign rsp_chan.packet_length = rsp_result.packet_length;
   assign rsp_chan.bytes_left    = rsp_result.bytes_left;
   assign rsp_chan.too_big       = rsp_result.too_big;
   assign rsp_chan.length_error  = rsp_result.length_error;
   assign rsp_chan.packet_done   = rsp_result.packet_done;
endmodule

@@ tb/mfh_framer_checker.sv @@
`timescale 1ns / 100ps
// response checker of the mqtt fixed header framer: predicts every byte's response and compares
module mfh_framer_checker (
   input  logic                      clock,
   input  logic                      reset,
   mfh_req_if                        req_mon,
   mfh_rsp_if                        rsp_mon,
   input  logic                      csr_wr_en,
   input  logic [mfh_pkg::LEN_W-1:0] csr_wr_data,
   output int                        fail_count,
   output int                        outstanding
);
   import mfh_pkg::*;

   // framer state as the stream has left it
   phase_type          frame_phase;
   logic [LEN_W-1:0]   length_sum;
   logic [IDX_W-1:0]   group_idx;
   logic [LEN_W-1:0]   body_left;
   logic               oversize;
   logic [DATA_W-1:0]  header_reg;
   logic [LEN_W-1:0]   size_limit;

   result_type         framed_bytes_q[$];
   result_type         oldest;
   int                 mismatches = 0;

   function automatic result_type frame_byte(input logic [DATA_W-1:0] b);
      result_type r;
      r = '0;
      case (frame_phase)
         PH_LENGTH: begin
            r.byte_role = ROLE_LENGTH;
            length_sum = length_sum | (LEN_W'(b[6:0]) << (GROUP_W * group_idx));
            if (b[7]) begin
               if (group_idx == LAST_LEN_IDX) begin
                  r.length_error = 1'b1;
                  frame_phase = PH_HEADER;
               end else begin
                  group_idx = group_idx + 1'b1;
               end
            end else begin
               oversize = (length_sum > size_limit);
               body_left = length_sum;
               r.packet_length = length_sum;
               r.bytes_left = length_sum;
               r.too_big = oversize;
               if (length_sum == '0) begin
                  r.packet_done = 1'b1;
                  frame_phase = PH_HEADER;
               end else begin
                  frame_phase = PH_BODY;
               end
            end
         end
         PH_BODY: begin
            r.byte_role = ROLE_BODY;
            body_left = body_left - 1'b1;
            r.packet_length = length_sum;
            r.bytes_left = body_left;
            r.too_big = oversize;
            if (body_left == '0) begin
               r.packet_done = 1'b1;
               frame_phase = PH_HEADER;
            end
         end
         default: begin
            r.byte_role = ROLE_HEADER;
            header_reg = b;
            length_sum = '0;
            group_idx = '0;
            body_left = '0;
            oversize = 1'b0;
            frame_phase = PH_LENGTH;
         end
      endcase
      r.packet_type = header_reg[7:4];
      r.header_flags = header_reg[3:0];
      return r;
   endfunction

   task automatic check_field(input string field, input logic [LEN_W-1:0] want,
                              input logic [LEN_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         frame_phase = PH_HEADER;
         length_sum = '0;
         group_idx = '0;
         body_left = '0;
         oversize = 1'b0;
         header_reg = '0;
         size_limit = MAX_SIZE_RESET;
         framed_bytes_q.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (framed_bytes_q.size() == 0) begin
               $display("%0t: response with none expected, expected nothing, actual role %0d len %0h",
                        $time, rsp_mon.byte_role, rsp_mon.packet_length);
               mismatches++;
            end else begin
               oldest = framed_bytes_q.pop_front();
               check_field("byte_role", LEN_W'(oldest.byte_role), LEN_W'(rsp_mon.byte_role));
               check_field("packet_type", LEN_W'(oldest.packet_type),
                           LEN_W'(rsp_mon.packet_type));
               check_field("header_flags", LEN_W'(oldest.header_flags),
                           LEN_W'(rsp_mon.header_flags));
               check_field("packet_length", oldest.packet_length,
                           rsp_mon.packet_length);
               check_field("bytes_left", oldest.bytes_left, rsp_mon.bytes_left);
               check_field("too_big", LEN_W'(oldest.too_big), LEN_W'(rsp_mon.too_big));
               check_field("length_error", LEN_W'(oldest.length_error),
                           LEN_W'(rsp_mon.length_error));
               check_field("packet_done", LEN_W'(oldest.packet_done),
                           LEN_W'(rsp_mon.packet_done));
            end
         end
         if (req_mon.valid && req_mon.ready)
            framed_bytes_q.insert(framed_bytes_q.size(), frame_byte(req_mon.data_byte));
         if (csr_wr_en)
            size_limit = csr_wr_data;
      end
      fail_count <= mismatches;
      outstanding <= framed_bytes_q.size();
   end

endmodule

@@ tb/mqtt_fixed_header_framer_test.sv @@
`timescale 1ns / 100ps
// regression top of the mqtt fixed header framer: stimulus, flow control and verdict
module mqtt_fixed_header_framer_test;
   import mfh_pkg::*;

   // generous: ~2000 bytes with random send gaps and receive stalls, plus drains
   localparam int CYCLE_LIMIT  = 400000;
   // a response passes the input and response registers after its request is taken
   localparam int DRAIN_CYCLES = 4;
   localparam int SEGMENT_SIZE = 310;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_wr_en;
   logic [LEN_W-1:0]  csr_wr_data;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int fail_count;
   int outstanding;
   int cycle_count;
   int bytes_sent = 0;

   // opening stream: zero length, bad length field, padded length encodings,
   // extreme header nibbles and body values
   logic [DATA_W-1:0] opening_bytes [20] = '{
      8'h00, 8'h00,                          // zero length, done on length byte
      8'hF0, 8'h80, 8'h80, 8'h80, 8'h80,     // continuation on fourth length byte
      8'h3B, 8'h83, 8'h00, 8'hFF, 8'h00, 8'h55, // length 3 padded to two bytes
      8'h82, 8'h80, 8'h80, 8'h00,            // zero length spread over three bytes
      8'hC0, 8'h01, 8'hAA                    // single body byte
   };

   // size limits per segment; the last segment picks a small random one
   logic [LEN_W-1:0] size_limits [5] = '{
      '0, LEN_W'(1), LEN_W'(7), MAX_SIZE_RESET, {LEN_W{1'b1}}
   };
   int idle_by_mode  [4] = '{0, 70, 0, 18};
   int stall_by_mode [4] = '{0, 0, 70, 18};

   mfh_req_if req_if ();
   mfh_rsp_if rsp_if ();

   mqtt_fixed_header_framer dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   mfh_framer_checker checker_0 (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_if),
      .rsp_mon     (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always #5 clock = ~clock;

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Regression FAIL");
      $finish;
   end

   // one byte per request; random gaps before it, then hold until taken
   task automatic push_byte(input logic [DATA_W-1:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data_byte <= b;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      bytes_sent++;
   endtask

   // length field, least significant group first; extra groups pad with zeros
   task automatic send_length(input logic [LEN_W-1:0] len, input int groups);
      logic [6:0] grp;
      for (int i = 0; i < groups; i++) begin
         grp = 7'(len >> (GROUP_W * i));
         push_byte({(i < groups - 1), grp});
      end
   endtask

   function automatic int min_groups(input int len);
      if (len < 128) return 1;
      if (len < 16384) return 2;
      if (len < 2097152) return 3;
      return 4;
   endfunction

   // mostly well-formed packets with random header and body, some broken ones
   task automatic send_packet();
      int kind;
      int len;
      int groups;
      kind = $urandom_range(99);
      push_byte(DATA_W'($urandom_range(255)));
      if (kind < 10) begin
         // malformed: four length bytes all with continuation set
         repeat (4) push_byte(8'h80 | DATA_W'($urandom_range(127)));
      end else begin
         if (kind < 20)
            len = 0;
         else if (kind < 28)
            len = $urandom_range(200, 64);
         else
            len = $urandom_range(20, 1);
         groups = min_groups(len);
         // sometimes a padded (non-minimal) encoding
         if ($urandom_range(4) == 0)
            groups = $urandom_range(4, groups);
         send_length(LEN_W'(len), groups);
         repeat (len) push_byte(DATA_W'($urandom_range(255)));
      end
   endtask

   // stop sending and let every expected response come back
   task automatic drain();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_size_limit(input logic [LEN_W-1:0] value);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int seg_end;
      req_if.valid <= 1'b0;
      req_if.data_byte <= '0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed opening at the reset size limit
      foreach (opening_bytes[i])
         push_byte(opening_bytes[i]);

      // random segments, each with its own size limit and flow-control mode
      seg_end = bytes_sent;
      for (int seg = 0; seg < 6; seg++) begin
         if (seg < 5)
            write_size_limit(size_limits[seg]);
         else
            write_size_limit(LEN_W'($urandom_range(64)));
         send_idle_pct <= idle_by_mode[seg % 4];
         recv_stall_pct <= stall_by_mode[seg % 4];
         seg_end += SEGMENT_SIZE;
         while (bytes_sent < seg_end)
            send_packet();
      end

      // largest encodable length, at the largest limit: body only started
      write_size_limit({LEN_W{1'b1}});
      push_byte(8'h1F);
      send_length({LEN_W{1'b1}}, 4);
      push_byte(8'hFF);
      push_byte(8'h00);
      push_byte(8'h5A);

      drain();
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

@@ files.f @@
rtl/mfh_pkg.sv
rtl/mfh_if.sv
rtl/mfh_in_reg.sv
rtl/mfh_decoder.sv
rtl/mfh_out_reg.sv
rtl/mqtt_fixed_header_framer.sv
tb/mfh_framer_checker.sv
tb/mqtt_fixed_header_framer_test.sv
